FILE: src/i2cms_pkg.sv
// Package: types, command codes and helpers shared by the I2C master bit sequencer.
package i2cms_pkg;

  localparam int unsigned TpmW    = 8;
  localparam int unsigned PollW   = 8;
  localparam int unsigned DelayW  = 11;
  localparam int unsigned PhaseW  = 4;
  localparam int unsigned BitIdxW = 4;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [TpmW-1:0]  TpmReset   = 8'd100;
  localparam logic [PollW-1:0] PollReset  = 8'd250;
  localparam logic [PollW-1:0] PollMax    = 8'hFF;
  localparam logic [BitIdxW-1:0] BitsPerByte = 4'd8;

  // bus delays in microseconds
  localparam logic [2:0] Us1 = 3'd1;
  localparam logic [2:0] Us2 = 3'd2;
  localparam logic [2:0] Us5 = 3'd5;
  localparam logic [2:0] Us6 = 3'd6;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_ACK   = 3'd3,
    CMD_NACK  = 3'd4,
    CMD_WAIT  = 3'd5,
    CMD_WRITE = 3'd6,
    CMD_READ  = 3'd7
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TICKS_PER_US = 1'b0,
    REG_ACK_TIMEOUT  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [ByteW-1:0] tx_byte;
    logic             ack_after_read;
    logic             sda_in;
  } in_word_t;

  typedef struct packed {
    logic             scl_out;
    logic             sda_out;
    logic             busy_res;
    logic             done_res;
    logic             ack_seen;
    logic             timed_out;
    logic [ByteW-1:0] rx_byte;
    logic             rejected;
  } out_word_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [PhaseW-1:0]  phase;
    logic [BitIdxW-1:0] bit_idx;
    logic [DelayW-1:0]  delay_left;
    logic [PollW-1:0]   poll_count;
    logic [ByteW-1:0]   shift_data;
    logic               scl_level;
    logic               sda_level;
    logic               ack_choice;
  } seq_state_t;

  typedef struct packed {
    logic [TpmW-1:0]  ticks_per_us;
    logic [PollW-1:0] ack_timeout;
  } cfg_t;

  // Delay of us microseconds in ticks; fits 11 bits for us up to 6.
  function automatic logic [DelayW-1:0] wait_ticks(logic [2:0] us, logic [TpmW-1:0] tpm);
    logic [DelayW-1:0] prod;
    prod = DelayW'(us) * DelayW'(tpm);
    return prod;
  endfunction

endpackage

FILE: src/i2cms_step.sv
// One tick of the pin sequencer: next state and result word from state and input word.
module i2cms_step (
  input  i2cms_pkg::seq_state_t state_i,
  input  i2cms_pkg::in_word_t   word_i,
  input  i2cms_pkg::cfg_t       cfg_i,
  output i2cms_pkg::seq_state_t state_o,
  output i2cms_pkg::out_word_t  word_o
);
  import i2cms_pkg::*;

  always_comb begin
    seq_state_t s;
    logic       run;
    logic       rej;
    logic       done;
    logic       ack;
    logic       tmo;
    logic [ByteW-1:0] rx;
    logic [PhaseW-1:0] p;
    logic [BitIdxW-1:0] nbit;

    s    = state_i;
    run  = 1'b0;
    rej  = 1'b0;
    done = 1'b0;
    ack  = 1'b0;
    tmo  = 1'b0;
    rx   = '0;
    nbit = '0;

    if (s.cmd != CMD_IDLE) begin
      rej = (word_i.req_type != 3'(CMD_IDLE));
      if (s.delay_left != '0) begin
        s.delay_left = s.delay_left - DelayW'(1);
      end else begin
        run = 1'b1;
      end
    end else if (word_i.req_type != 3'(CMD_IDLE)) begin
      s.cmd        = cmd_e'(word_i.req_type);
      s.phase      = '0;
      s.bit_idx    = '0;
      s.poll_count = '0;
      s.delay_left = '0;
      s.shift_data = (s.cmd == CMD_WRITE) ? word_i.tx_byte : '0;
      s.ack_choice = (s.cmd == CMD_READ) ? word_i.ack_after_read : 1'b0;
      run          = 1'b1;
    end

    p = s.phase;
    if (run) begin
      s.delay_left = '0;
      unique case (s.cmd)
        CMD_START: begin
          priority if (p == 4'd0) begin
            s.sda_level = 1'b1;
          end else if (p == 4'd1) begin
            s.scl_level = 1'b1; s.delay_left = wait_ticks(Us5, cfg_i.ticks_per_us);
          end else if (p == 4'd2) begin
            s.sda_level = 1'b0; s.delay_left = wait_ticks(Us6, cfg_i.ticks_per_us);
          end else if (p == 4'd3) begin
            s.scl_level = 1'b0;
          end else begin
            done = 1'b1; s.cmd = CMD_IDLE;
          end
          s.phase = (p >= 4'd4) ? '0 : p + PhaseW'(1);
        end
        CMD_STOP: begin
          priority if (p == 4'd0) begin
            s.scl_level = 1'b0;
          end else if (p == 4'd1) begin
            s.sda_level = 1'b0;
          end else if (p == 4'd2) begin
            s.scl_level = 1'b1; s.delay_left = wait_ticks(Us6, cfg_i.ticks_per_us);
          end else if (p == 4'd3) begin
            s.sda_level = 1'b1; s.delay_left = wait_ticks(Us6, cfg_i.ticks_per_us);
          end else begin
            done = 1'b1; s.cmd = CMD_IDLE;
          end
          s.phase = (p >= 4'd4) ? '0 : p + PhaseW'(1);
        end
        CMD_ACK, CMD_NACK: begin
          priority if (p == 4'd0) begin
            s.scl_level = 1'b0;
          end else if (p == 4'd1) begin
            s.sda_level  = (s.cmd == CMD_NACK);
            s.delay_left = wait_ticks(Us2, cfg_i.ticks_per_us);
          end else if (p == 4'd2) begin
            s.scl_level = 1'b1; s.delay_left = wait_ticks(Us5, cfg_i.ticks_per_us);
          end else if (p == 4'd3) begin
            s.scl_level = 1'b0;
          end else begin
            done = 1'b1; s.cmd = CMD_IDLE;
          end
          s.phase = (p >= 4'd4) ? '0 : p + PhaseW'(1);
        end
        CMD_WAIT: begin
          priority if (p == 4'd0) begin
            s.sda_level = 1'b1; s.delay_left = wait_ticks(Us1, cfg_i.ticks_per_us);
            s.phase = 4'd1;
          end else if (p == 4'd1) begin
            s.scl_level = 1'b1; s.delay_left = wait_ticks(Us1, cfg_i.ticks_per_us);
            s.phase = 4'd2;
          end else if (p == 4'd2) begin
            if (!word_i.sda_in) begin
              s.scl_level  = 1'b0;
              s.ack_choice = 1'b1;
              s.phase      = 4'd3;
            end else begin
              if (s.poll_count != PollMax) s.poll_count = s.poll_count + PollW'(1);
              if (s.poll_count >= cfg_i.ack_timeout) s.phase = 4'd4;
            end
          end else if (p == 4'd3) begin
            done = 1'b1; ack = s.ack_choice; s.cmd = CMD_IDLE; s.phase = '0;
          end else if (p == 4'd4) begin
            s.scl_level = 1'b0; s.phase = 4'd5;
          end else if (p == 4'd5) begin
            s.sda_level = 1'b0; s.phase = 4'd6;
          end else if (p == 4'd6) begin
            s.scl_level = 1'b1; s.delay_left = wait_ticks(Us6, cfg_i.ticks_per_us);
            s.phase = 4'd7;
          end else if (p == 4'd7) begin
            s.sda_level = 1'b1; s.delay_left = wait_ticks(Us6, cfg_i.ticks_per_us);
            s.phase = 4'd8;
          end else begin
            done = 1'b1; tmo = 1'b1; s.cmd = CMD_IDLE; s.phase = '0;
          end
        end
        CMD_WRITE: begin
          priority if (p == 4'd0) begin
            s.scl_level = 1'b0; s.phase = 4'd1;
          end else if (p == 4'd1) begin
            s.sda_level  = s.shift_data[ByteW-1];
            s.shift_data = {s.shift_data[ByteW-2:0], 1'b0};
            s.delay_left = wait_ticks(Us2, cfg_i.ticks_per_us);
            s.phase      = 4'd2;
          end else if (p == 4'd2) begin
            s.scl_level = 1'b1; s.delay_left = wait_ticks(Us2, cfg_i.ticks_per_us);
            s.phase = 4'd3;
          end else if (p == 4'd3) begin
            s.scl_level  = 1'b0;
            s.delay_left = wait_ticks(Us2, cfg_i.ticks_per_us);
            nbit         = s.bit_idx + BitIdxW'(1);
            s.bit_idx    = nbit;
            s.phase      = (nbit < BitsPerByte) ? 4'd1 : 4'd4;
          end else begin
            done = 1'b1; s.cmd = CMD_IDLE; s.phase = '0;
          end
        end
        CMD_READ: begin
          priority if (p == 4'd0) begin
            s.scl_level = 1'b0; s.delay_left = wait_ticks(Us2, cfg_i.ticks_per_us);
            s.phase = 4'd1;
          end else if (p == 4'd1) begin
            s.scl_level  = 1'b1;
            s.shift_data = {s.shift_data[ByteW-2:0], word_i.sda_in};
            s.delay_left = wait_ticks(Us1, cfg_i.ticks_per_us);
            nbit         = s.bit_idx + BitIdxW'(1);
            s.bit_idx    = nbit;
            s.phase      = (nbit < BitsPerByte) ? 4'd0 : 4'd2;
          end else if (p == 4'd2) begin
            s.scl_level = 1'b0; s.phase = 4'd3;
          end else if (p == 4'd3) begin
            s.sda_level  = !s.ack_choice;
            s.delay_left = wait_ticks(Us2, cfg_i.ticks_per_us);
            s.phase      = 4'd4;
          end else if (p == 4'd4) begin
            s.scl_level = 1'b1; s.delay_left = wait_ticks(Us5, cfg_i.ticks_per_us);
            s.phase = 4'd5;
          end else if (p == 4'd5) begin
            s.scl_level = 1'b0; s.phase = 4'd6;
          end else begin
            done = 1'b1; rx = s.shift_data; s.cmd = CMD_IDLE; s.phase = '0;
          end
        end
        default: begin
          s.cmd   = CMD_IDLE;
          s.phase = '0;
        end
      endcase
    end

    state_o          = s;
    word_o.scl_out   = s.scl_level;
    word_o.sda_out   = s.sda_level;
    word_o.busy_res  = (s.cmd != CMD_IDLE);
    word_o.done_res  = done;
    word_o.ack_seen  = ack;
    word_o.timed_out = tmo;
    word_o.rx_byte   = rx;
    word_o.rejected  = rej;
  end

endmodule

FILE: src/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer: input register, tick logic, result register.
// Path: a word accepted into the input register reaches the output through the result register.
// Throughput: one word per cycle unless out_stall_i holds a result; the sequencer state
//   updates once per word moved into the result register, one tick per unstalled clock.
// Reset: rst_ni low clears both stages, leaves the sequencer idle with SCL and SDA released,
//   and restores 100 ticks per microsecond and 250 acknowledge polls.
module i2c_master_bit_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tick words in
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  i2cms_pkg::in_word_t            in_word_i,
  // result words out
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output i2cms_pkg::out_word_t           out_word_o,
  // register writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [i2cms_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);
  import i2cms_pkg::*;

  // Input register: holds one tick word until the result register can take its result.
  logic       s1_valid_q;
  in_word_t   s1_q;
  // Result register.
  logic       out_valid_q;
  out_word_t  out_q;
  // Sequencer state and registers.
  seq_state_t state_q, state_d;
  out_word_t  res_d;
  cfg_t       cfg_q;

  logic out_free;
  logic advance;
  logic in_take;

  // The result register frees up when empty or when its word leaves this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // The user must issue writes only while idle; the block does not enforce this and accepts them at once.
  assign cfg_ready_o = 1'b1;

  i2cms_step u_step (
    .state_i (state_q),
    .word_i  (s1_q),
    .cfg_i   (cfg_q),
    .state_o (state_d),
    .word_o  (res_d)
  );

  // Advance the input stage; hold it when the result side stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_word_i;
    end
  end

  // Load the result register and commit the sequencer state in the same edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.cmd        <= CMD_IDLE;
      state_q.phase      <= '0;
      state_q.bit_idx    <= '0;
      state_q.delay_left <= '0;
      state_q.poll_count <= '0;
      state_q.shift_data <= '0;
      state_q.scl_level  <= 1'b1;
      state_q.sda_level  <= 1'b1;
      state_q.ack_choice <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Register file: two 8-bit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_us <= TpmReset;
      cfg_q.ack_timeout  <= PollReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_TICKS_PER_US: cfg_q.ticks_per_us <= cfg_data_i;
        REG_ACK_TIMEOUT:  cfg_q.ack_timeout  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

FILE: src/i2cms_checker.sv
// Port checker for the I2C master bit sequencer, bound to the top level.
module i2cms_props (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input i2cms_pkg::out_word_t out_word_o
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed under stall");

  // The input only pushes back while a result word is held up.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with the result side free");

  // A finishing tick leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.done_res && out_word_o.busy_res))
    else $error("done and busy together");

  // Acknowledge and timeout reports only come with completion, never both.
  a_ack_tmo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.ack_seen || out_word_o.timed_out) |->
      out_word_o.done_res && !(out_word_o.ack_seen && out_word_o.timed_out))
    else $error("acknowledge report without completion");

  // Read data appears only on a completion tick.
  a_rx_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.rx_byte != '0) |-> out_word_o.done_res)
    else $error("read byte outside completion");

endmodule

bind i2c_master_bit_sequencer i2cms_props u_i2cms_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
